@@ src/channel_slice_allocator_macros.svh @@
// ----------------------------------------------------------------------------
// Channel slice allocator assertion macros
// Concurrent assertion forms shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef CHANNEL_SLICE_ALLOCATOR_MACROS_SVH
`define CHANNEL_SLICE_ALLOCATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CSA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CSA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/csa_pkg.sv @@
// ----------------------------------------------------------------------------
// Channel slice allocator package
// Transfer types, result codes and saturating counter helpers.
// ----------------------------------------------------------------------------
package csa_pkg;

  localparam int VIEW_W  = 11;
  localparam int USED_W  = 7;
  localparam int BLOCK_W = 16;
  localparam int CFG_W   = 7;

  localparam logic [VIEW_W-1:0]  VIEW_MAX  = 11'd2047;
  localparam logic [BLOCK_W-1:0] BLOCK_MAX = 16'hFFFF;
  localparam logic [CFG_W-1:0]   SA_RESET  = 7'd64;

  typedef enum logic [1:0] {
    ST_JOINED  = 2'd0,
    ST_MEMBER  = 2'd1,
    ST_ALLOC   = 2'd2,
    ST_BLOCKED = 2'd3
  } status_e;

  typedef struct packed {
    logic [9:0] user_id;
    logic       leave_valid;
    logic [7:0] prev_channel;
    logic [7:0] next_channel;
  } evt_t;

  typedef struct packed {
    status_e              status;
    logic [5:0]           slice_index;
    logic                 slice_freed;
    logic [5:0]           freed_slice;
    logic [USED_W-1:0]    slices_used;
    logic [VIEW_W-1:0]    active_users;
    logic [USED_W-1:0]    peak_slices;
    logic [BLOCK_W-1:0]   blocked_total;
  } res_t;

  function automatic logic [VIEW_W-1:0] sat_inc(input logic [VIEW_W-1:0] v);
    return (v < VIEW_MAX) ? VIEW_W'(v + 11'd1) : v;
  endfunction

  function automatic logic [VIEW_W-1:0] sat_dec(input logic [VIEW_W-1:0] v);
    return (v != '0) ? VIEW_W'(v - 11'd1) : v;
  endfunction

endpackage

@@ src/csa_free_search.sv @@
// ----------------------------------------------------------------------------
// Free slice search
// Two-stage registered search for the lowest slice whose busy flag is clear.
// ----------------------------------------------------------------------------
module csa_free_search import csa_pkg::*; #(
  parameter int SLICES = 64
) (
  input  logic                                  clk_i,
  input  logic [SLICES-1:0]                     busy_i,
  output logic                                  found_o,
  output logic [(SLICES > 1 ? $clog2(SLICES) : 1)-1:0] index_o
);

  localparam int SW   = (SLICES > 1) ? $clog2(SLICES) : 1;
  localparam int GRP  = 8;
  localparam int NGRP = (SLICES + GRP - 1) / GRP;
  localparam int PADW = NGRP * GRP;

  logic [PADW-1:0] free_pad;
  logic [NGRP-1:0] grp_any_d, grp_any_q;
  logic [2:0]      grp_lo_d [NGRP];
  logic [2:0]      grp_lo_q [NGRP];
  logic            found_d;
  logic [SW-1:0]   index_d;

  assign free_pad = PADW'(~busy_i);

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_any_d[g] = 1'b0;
      grp_lo_d[g]  = '0;
      for (int k = GRP - 1; k >= 0; k--) begin
        if (free_pad[g*GRP + k]) begin
          grp_any_d[g] = 1'b1;
          grp_lo_d[g]  = 3'(k);
        end
      end
    end
  end

  always_comb begin
    found_d = 1'b0;
    index_d = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (grp_any_q[g]) begin
        found_d = 1'b1;
        index_d = SW'((g * GRP) + int'(grp_lo_q[g]));
      end
    end
  end

  always_ff @(posedge clk_i) begin
    grp_any_q <= grp_any_d;
    grp_lo_q  <= grp_lo_d;
    found_o   <= found_d;
    index_o   <= index_d;
  end

endmodule

@@ src/channel_slice_allocator.sv @@
// ----------------------------------------------------------------------------
// Channel slice allocator
// Reference-counted mapping of requested channels onto a limited set of
// slices, with per-channel and per-user tables held in synchronous memory.
//
//   Channel   Dir  Handshake           Payload
//   event     in   start / busy        item_i   (evt_t)
//   result    out  done_o strobe       result_o (res_t)
//   config    in   cfg_we_i            cfg_data_i (slices_available)
//
// An event runs as table reads at the accepting edge, the leave update,
// then the join or grant with write-back of both tables.
// The result strobe is registered in the join and shows in the cycle after,
// and the next start may be accepted in that same cycle; events never overlap.
// After reset a clearing pass over max(CHANNELS, USERS) table entries keeps busy high.
// The receiver cannot stall: each result is valid for exactly one cycle.
// ----------------------------------------------------------------------------
`include "channel_slice_allocator_macros.svh"

module channel_slice_allocator import csa_pkg::*; #(
  parameter int CHANNELS = 256,
  parameter int SLICES   = 64,
  parameter int USERS    = 1024
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  evt_t             item_i,
  output logic             done_o,
  output res_t             result_o,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int CAW   = $clog2(CHANNELS);
  localparam int UAW   = $clog2(USERS);
  localparam int SW    = (SLICES > 1) ? $clog2(SLICES) : 1;
  localparam int DEPTH = (CHANNELS > USERS) ? CHANNELS : USERS;
  localparam int CLRW  = $clog2(DEPTH);

  typedef struct packed {
    logic [VIEW_W-1:0] viewers;
    logic              on_air;
    logic [SW-1:0]     slice;
  } chan_t;

  typedef struct packed {
    logic           watching;
    logic [CAW-1:0] chan;
  } user_t;

  typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_LEAVE, S_JOIN} state_e;

  chan_t chan_mem [CHANNELS];
  user_t user_mem [USERS];

  state_e              state_q;
  logic [CLRW-1:0]     clr_q;
  evt_t                evt_q;
  chan_t               prev_rd_q, next_rd_q, prev_new_q;
  user_t               user_rd_q;
  logic                leave_eff_q, freed_q;
  logic [SW-1:0]       freed_idx_q;
  logic [SLICES-1:0]   busy_q;
  logic [USED_W-1:0]   used_q, peak_q;
  logic [VIEW_W-1:0]   active_q;
  logic [BLOCK_W-1:0]  blocked_q;
  logic [CFG_W-1:0]    sa_q;
  logic                done_q;
  res_t                res_q;

  logic                accept;
  logic                srch_found;
  logic [SW-1:0]       srch_idx;

  // Leave stage
  logic                prev_ok, lv_eff, lv_free;
  chan_t               lv_new;

  // Join stage
  chan_t               nx, nx_new;
  user_t               u, u_new;
  logic                user_ok, next_ok, grant, j_ch_we, add_view;
  logic [CAW-1:0]      next_addr_q, prev_addr_q;
  logic [CFG_W-1:0]    limit;
  logic                cand_found;
  logic [SW-1:0]       cand, j_slice;
  status_e             j_status;
  logic [USED_W-1:0]   used_inc;

  // Memory write ports
  logic                ch_we, us_we;
  logic [CAW-1:0]      ch_waddr;
  chan_t               ch_wdata;

  assign accept = start && !busy;
  assign busy   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  assign prev_addr_q = CAW'(32'(evt_q.prev_channel));
  assign next_addr_q = CAW'(32'(evt_q.next_channel));

  csa_free_search #(
    .SLICES (SLICES)
  ) u_search (
    .clk_i   (clk_i),
    .busy_i  (busy_q),
    .found_o (srch_found),
    .index_o (srch_idx)
  );

  always_comb begin
    prev_ok = 32'(evt_q.prev_channel) < CHANNELS;
    lv_eff  = evt_q.leave_valid && prev_ok && prev_rd_q.on_air;
    lv_new  = prev_rd_q;
    lv_new.viewers = sat_dec(prev_rd_q.viewers);
    lv_free = lv_eff && (lv_new.viewers == '0);
    if (lv_new.viewers == '0) begin
      lv_new.on_air = 1'b0;
    end
  end

  always_comb begin
    user_ok = 32'(evt_q.user_id) < USERS;
    next_ok = 32'(evt_q.next_channel) < CHANNELS;
    limit   = (32'(sa_q) < SLICES) ? sa_q : CFG_W'(SLICES);

    if (leave_eff_q && (evt_q.prev_channel == evt_q.next_channel)) begin
      nx = prev_new_q;
    end else begin
      nx = next_rd_q;
    end

    u = user_rd_q;
    if (leave_eff_q && u.watching && (u.chan == prev_addr_q)) begin
      u.watching = 1'b0;
    end

    if (freed_q && (!srch_found || (freed_idx_q < srch_idx))) begin
      cand       = freed_idx_q;
      cand_found = 1'b1;
    end else begin
      cand       = srch_idx;
      cand_found = srch_found;
    end

    used_inc = USED_W'(used_q + 7'd1);
    nx_new   = nx;
    u_new    = u;
    grant    = 1'b0;
    j_ch_we  = 1'b0;
    add_view = 1'b0;
    j_status = ST_BLOCKED;
    j_slice  = '0;

    priority if (next_ok && nx.on_air) begin
      j_slice = nx.slice;
      if (user_ok && u.watching && (u.chan == next_addr_q)) begin
        j_status = ST_MEMBER;
      end else begin
        j_status       = ST_JOINED;
        j_ch_we        = 1'b1;
        add_view       = 1'b1;
        nx_new.viewers = sat_inc(nx.viewers);
        u_new.watching = 1'b1;
        u_new.chan     = next_addr_q;
      end
    end else if (next_ok && cand_found && (32'(cand) < 32'(limit)) && (used_q < limit)) begin
      j_status       = ST_ALLOC;
      j_slice        = cand;
      grant          = 1'b1;
      j_ch_we        = 1'b1;
      add_view       = 1'b1;
      nx_new.viewers = VIEW_W'(1);
      nx_new.on_air  = 1'b1;
      nx_new.slice   = cand;
      u_new.watching = 1'b1;
      u_new.chan     = next_addr_q;
    end else begin
      j_status = ST_BLOCKED;
    end
  end

  always_comb begin
    ch_we    = 1'b0;
    ch_waddr = prev_addr_q;
    ch_wdata = lv_new;
    us_we    = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        ch_we    = 32'(clr_q) < CHANNELS;
        ch_waddr = CAW'(clr_q);
        ch_wdata = '0;
      end
      S_LEAVE: begin
        ch_we    = lv_eff;
        ch_waddr = prev_addr_q;
        ch_wdata = lv_new;
      end
      S_JOIN: begin
        ch_we    = j_ch_we;
        ch_waddr = next_addr_q;
        ch_wdata = nx_new;
        us_we    = user_ok;
      end
      default: begin
        ch_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ch_we) begin
      chan_mem[ch_waddr] <= ch_wdata;
    end
    if (accept) begin
      prev_rd_q <= chan_mem[CAW'(32'(item_i.prev_channel))];
      next_rd_q <= chan_mem[CAW'(32'(item_i.next_channel))];
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_CLEAR) && (32'(clr_q) < USERS)) begin
      user_mem[UAW'(clr_q)] <= '0;
    end else if (us_we) begin
      user_mem[UAW'(32'(evt_q.user_id))] <= u_new;
    end
    if (accept) begin
      user_rd_q <= user_mem[UAW'(32'(item_i.user_id))];
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      evt_q <= item_i;
    end
    if (state_q == S_LEAVE) begin
      prev_new_q  <= lv_new;
      freed_idx_q <= prev_rd_q.slice;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q <= SA_RESET;
    end else if (cfg_we_i) begin
      sa_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      leave_eff_q <= 1'b0;
      freed_q     <= 1'b0;
      busy_q      <= '0;
      used_q      <= '0;
      peak_q      <= '0;
      active_q    <= '0;
      blocked_q   <= '0;
      done_q      <= 1'b0;
      res_q       <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= CLRW'(clr_q + 1'b1);
          if (clr_q == CLRW'(DEPTH - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state_q <= S_LEAVE;
          end
        end
        S_LEAVE: begin
          leave_eff_q <= lv_eff;
          freed_q     <= lv_free;
          if (lv_eff && (active_q != '0)) begin
            active_q <= VIEW_W'(active_q - 11'd1);
          end
          if (lv_free) begin
            busy_q[prev_rd_q.slice] <= 1'b0;
            if (used_q != '0) begin
              used_q <= USED_W'(used_q - 7'd1);
            end
          end
          state_q <= S_JOIN;
        end
        S_JOIN: begin
          res_q.status        <= j_status;
          res_q.slice_index   <= 6'(32'(j_slice));
          res_q.slice_freed   <= freed_q;
          res_q.freed_slice   <= freed_q ? 6'(32'(freed_idx_q)) : 6'd0;
          res_q.slices_used   <= grant ? used_inc : used_q;
          res_q.active_users  <= (add_view && (active_q < VIEW_MAX)) ?
                                 VIEW_W'(active_q + 11'd1) : active_q;
          res_q.peak_slices   <= (grant && (used_inc > peak_q)) ? used_inc : peak_q;
          res_q.blocked_total <= ((j_status == ST_BLOCKED) && (blocked_q < BLOCK_MAX)) ?
                                 BLOCK_W'(blocked_q + 16'd1) : blocked_q;
          if (add_view && (active_q < VIEW_MAX)) begin
            active_q <= VIEW_W'(active_q + 11'd1);
          end
          if (grant) begin
            busy_q[cand] <= 1'b1;
            used_q       <= used_inc;
            if (used_inc > peak_q) begin
              peak_q <= used_inc;
            end
          end
          if ((j_status == ST_BLOCKED) && (blocked_q < BLOCK_MAX)) begin
            blocked_q <= BLOCK_W'(blocked_q + 16'd1);
          end
          done_q  <= 1'b1;
          state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  `CSA_ASSERT_NXT(a_done_after_join, clk_i, rst_ni, state_q == S_JOIN, done_o, "Missing result strobe after join.")
  `CSA_ASSERT_NXT(a_no_stray_done, clk_i, rst_ni, state_q != S_JOIN, !done_o, "Result strobe without a join.")
  `CSA_ASSERT_IMP(a_used_matches_busy, clk_i, rst_ni, state_q == S_IDLE, $countones(busy_q) == int'(used_q), "Slice count disagrees with busy flags.")
  `CSA_ASSERT_IMP(a_blocked_no_slice, clk_i, rst_ni, done_o && (result_o.status == ST_BLOCKED), result_o.slice_index == 6'd0, "Blocked transfer reports a slice.")

endmodule

@@ tb/tb_channel_slice_allocator.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Channel slice allocator testbench
// Drives channel change events through the start/busy port and keeps its own
// copy of the channel, slice and user tables to predict every result
// transfer. Each result is checked field by field against the oldest
// prediction. Directed events cover grants, joins, members, frees, blocks
// and odd leaves. Random phases follow at several slice limits.
// ----------------------------------------------------------------------------
module tb_channel_slice_allocator;
  import csa_pkg::*;

  localparam int unsigned CYCLE_LIMIT   = 200_000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef struct {
    evt_t        ev;
    int unsigned gap;
  } pend_t;

  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             start      = 1'b0;
  logic             busy;
  evt_t             item_i     = '0;
  logic             done_o;
  res_t             result_o;
  logic             cfg_we_i   = 1'b0;
  logic [CFG_W-1:0] cfg_data_i = SA_RESET;

  channel_slice_allocator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .done_o     (done_o),
    .result_o   (result_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Allocator tables as the design should hold them.
  logic [10:0]      chan_viewers_q [256];
  bit               chan_on_air_q  [256];
  logic [5:0]       chan_slice_q   [256];
  bit               slice_busy_q   [64];
  logic [10:0]      slice_viewers_q[64];
  logic [7:0]       user_chan_q    [1024];
  bit               user_watch_q   [1024];
  logic [6:0]       used_q;
  logic [10:0]      active_q;
  logic [6:0]       peak_q;
  logic [15:0]      blocked_q;
  logic [CFG_W-1:0] slice_limit_q;

  // Generator view of where each user sits, used to build well-formed moves.
  logic [7:0] gen_chan [1024];
  bit         gen_watch[1024];

  pend_t       channel_events[$];
  res_t        expected_allocs[$];
  int unsigned gap_left;
  bit          gap_armed;
  int unsigned fail_count;
  int unsigned results_seen;
  int unsigned cycle_count;

  function automatic res_t predict_allocation(evt_t ev);
    res_t        r;
    logic [5:0]  s;
    int unsigned lim;
    int unsigned p;
    bit          found;
    r = '0;
    r.status = ST_BLOCKED;
    if (ev.leave_valid && chan_on_air_q[ev.prev_channel]) begin
      s = chan_slice_q[ev.prev_channel];
      if (chan_viewers_q[ev.prev_channel] != 0) chan_viewers_q[ev.prev_channel]--;
      if (active_q != 0) active_q--;
      if (slice_viewers_q[s] != 0) slice_viewers_q[s]--;
      if (user_watch_q[ev.user_id] && user_chan_q[ev.user_id] == ev.prev_channel)
        user_watch_q[ev.user_id] = 1'b0;
      if (chan_viewers_q[ev.prev_channel] == 0) begin
        chan_on_air_q[ev.prev_channel] = 1'b0;
        slice_busy_q[s] = 1'b0;
        slice_viewers_q[s] = '0;
        if (used_q != 0) used_q--;
        r.slice_freed = 1'b1;
        r.freed_slice = s;
      end
    end
    if (chan_on_air_q[ev.next_channel]) begin
      s = chan_slice_q[ev.next_channel];
      r.slice_index = s;
      if (user_watch_q[ev.user_id] && user_chan_q[ev.user_id] == ev.next_channel) begin
        r.status = ST_MEMBER;
      end else begin
        r.status = ST_JOINED;
        if (chan_viewers_q[ev.next_channel] != VIEW_MAX) chan_viewers_q[ev.next_channel]++;
        if (slice_viewers_q[s] != VIEW_MAX) slice_viewers_q[s]++;
        if (active_q != VIEW_MAX) active_q++;
        user_chan_q[ev.user_id] = ev.next_channel;
        user_watch_q[ev.user_id] = 1'b1;
      end
    end else begin
      lim = (slice_limit_q < 64) ? slice_limit_q : 64;
      found = 1'b0;
      p = 0;
      if (used_q < lim) begin
        for (int i = int'(lim) - 1; i >= 0; i--) begin
          if (!slice_busy_q[i]) begin
            p = i;
            found = 1'b1;
          end
        end
      end
      if (found) begin
        r.status = ST_ALLOC;
        r.slice_index = 6'(p);
        slice_busy_q[p] = 1'b1;
        slice_viewers_q[p] = 11'd1;
        chan_on_air_q[ev.next_channel] = 1'b1;
        chan_slice_q[ev.next_channel] = 6'(p);
        chan_viewers_q[ev.next_channel] = 11'd1;
        used_q++;
        if (used_q > peak_q) peak_q = used_q;
        if (active_q != VIEW_MAX) active_q++;
        user_chan_q[ev.user_id] = ev.next_channel;
        user_watch_q[ev.user_id] = 1'b1;
      end
    end
    if (r.status == ST_BLOCKED) begin
      r.slice_index = '0;
      if (blocked_q != BLOCK_MAX) blocked_q++;
    end
    r.slices_used   = used_q;
    r.active_users  = active_q;
    r.peak_slices   = peak_q;
    r.blocked_total = blocked_q;
    return r;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(3, 1);
    if (roll < 97) return $urandom_range(10, 4);
    return $urandom_range(40, 15);
  endfunction

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v)
      note_failure($sformatf("result %0d %s: expected %0d, got %0d",
                             results_seen, name, want_v, got_v));
  endtask

  task automatic queue_event(logic [9:0] user, logic leave, logic [7:0] prev,
                             logic [7:0] next, int unsigned gap);
    pend_t p;
    p.ev.user_id      = user;
    p.ev.leave_valid  = leave;
    p.ev.prev_channel = prev;
    p.ev.next_channel = next;
    p.gap             = gap;
    channel_events = {channel_events, p};
  endtask

  task automatic wait_drained();
    while (channel_events.size() != 0 || start || expected_allocs.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_limit(logic [CFG_W-1:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    slice_limit_q = value;
    @(negedge clk_i);
  endtask

  // Mostly well-formed moves: leave the channel the user sits on, then ask
  // for another. The rest is noise with every field random.
  task automatic run_random_phase(logic [CFG_W-1:0] limit, int unsigned count,
                                  int unsigned user_span, int unsigned chan_span);
    int unsigned u;
    int unsigned roll;
    bit          quiet;
    logic [7:0]  next;
    write_limit(limit);
    quiet = 1'b0;
    for (int unsigned k = 0; k < count; k++) begin
      if (k % 40 == 0) quiet = ($urandom_range(3) == 0);
      roll = $urandom_range(99);
      u = $urandom_range(user_span - 1);
      if (roll < 8 && gen_watch[u]) begin
        queue_event(10'(u), 1'b0, 8'($urandom_range(255)), gen_chan[u],
                    quiet ? 0 : pick_gap());
      end else if (roll < 75) begin
        next = 8'($urandom_range(chan_span - 1));
        queue_event(10'(u), roll >= 15 && gen_watch[u],
                    gen_watch[u] ? gen_chan[u] : 8'($urandom_range(255)), next,
                    quiet ? 0 : pick_gap());
        gen_chan[u]  = next;
        gen_watch[u] = 1'b1;
      end else begin
        queue_event(10'($urandom_range(1023)), 1'($urandom_range(1)),
                    8'($urandom_range(255)), 8'($urandom_range(255)),
                    quiet ? 0 : pick_gap());
      end
    end
    wait_drained();
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bit next_start;
    bit free;
    if (!rst_ni) begin
      start     <= 1'b0;
      item_i    <= '0;
      gap_left  = 0;
      gap_armed = 1'b0;
    end else begin
      next_start = start;
      free = !start;
      if (start && !busy) begin
        expected_allocs = {expected_allocs, predict_allocation(item_i)};
        next_start = 1'b0;
        free = 1'b1;
      end
      if (free && channel_events.size() != 0) begin
        if (!gap_armed) begin
          gap_left  = channel_events[0].gap;
          gap_armed = 1'b1;
        end
        if (gap_left != 0) begin
          gap_left--;
        end else begin
          item_i     <= channel_events[0].ev;
          void'(channel_events.pop_front());
          next_start = 1'b1;
          gap_armed  = 1'b0;
        end
      end
      start <= next_start;
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && done_o) begin
      if (expected_allocs.size() == 0) begin
        note_failure($sformatf("result %0d arrived with no event outstanding",
                               results_seen));
      end else begin
        want = expected_allocs.pop_front();
        check_field("status",        16'(want.status),        16'(result_o.status));
        check_field("slice_index",   16'(want.slice_index),   16'(result_o.slice_index));
        check_field("slice_freed",   16'(want.slice_freed),   16'(result_o.slice_freed));
        check_field("freed_slice",   16'(want.freed_slice),   16'(result_o.freed_slice));
        check_field("slices_used",   16'(want.slices_used),   16'(result_o.slices_used));
        check_field("active_users",  16'(want.active_users),  16'(result_o.active_users));
        check_field("peak_slices",   16'(want.peak_slices),   16'(result_o.peak_slices));
        check_field("blocked_total", want.blocked_total,      result_o.blocked_total);
      end
      results_seen++;
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** channel_slice_allocator: FAILED **");
      $finish;
    end
  end

  initial begin
    for (int c = 0; c < 256; c++) begin
      chan_viewers_q[c] = '0;
      chan_on_air_q[c]  = 1'b0;
      chan_slice_q[c]   = '0;
    end
    for (int s = 0; s < 64; s++) begin
      slice_busy_q[s]    = 1'b0;
      slice_viewers_q[s] = '0;
    end
    for (int u = 0; u < 1024; u++) begin
      user_chan_q[u]  = '0;
      user_watch_q[u] = 1'b0;
      gen_chan[u]     = '0;
      gen_watch[u]    = 1'b0;
    end
    used_q        = '0;
    active_q      = '0;
    peak_q        = '0;
    blocked_q     = '0;
    slice_limit_q = SA_RESET;
    fail_count    = 0;
    results_seen  = 0;
    cycle_count   = 0;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (busy !== 1'b0) @(negedge clk_i);

    // Two slices only, so grants, frees and blocks all show up quickly.
    write_limit(7'd2);
    queue_event(10'd0,   1'b1, 8'd255, 8'd0,   pick_gap());
    queue_event(10'd0,   1'b0, 8'd0,   8'd0,   pick_gap());
    queue_event(10'd1023, 1'b0, 8'd0,  8'd0,   pick_gap());
    queue_event(10'd1,   1'b0, 8'd0,   8'd255, pick_gap());
    queue_event(10'd2,   1'b0, 8'd0,   8'd128, pick_gap());
    queue_event(10'd1023, 1'b1, 8'd0,  8'd255, pick_gap());
    queue_event(10'd0,   1'b1, 8'd0,   8'd128, pick_gap());
    queue_event(10'd5,   1'b1, 8'd128, 8'd255, pick_gap());
    queue_event(10'd0,   1'b0, 8'd0,   8'd255, pick_gap());
    queue_event(10'd3,   1'b1, 8'd255, 8'd255, pick_gap());
    queue_event(10'd7,   1'b1, 8'd255, 8'd64,  pick_gap());
    queue_event(10'd7,   1'b1, 8'd64,  8'd64,  pick_gap());
    queue_event(10'd512, 1'b0, 8'd0,   8'd127, pick_gap());
    queue_event(10'd341, 1'b1, 8'd170, 8'd85,  pick_gap());
    queue_event(10'd682, 1'b1, 8'd85,  8'd170, pick_gap());
    wait_drained();

    run_random_phase(7'd64,  160, 200,  100);
    run_random_phase(7'd1,   80,  16,   8);
    run_random_phase(7'd4,   120, 40,   12);
    run_random_phase(7'd127, 100, 1024, 256);
    run_random_phase(7'd0,   30,  32,   16);
    run_random_phase(7'd33,  120, 120,  60);
    run_random_phase(7'd64,  30,  256,  64);

    if (fail_count == 0) begin
      $display("** channel_slice_allocator: PASSED **");
    end else begin
      $display("** channel_slice_allocator: FAILED **");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/csa_pkg.sv
src/csa_free_search.sv
src/channel_slice_allocator.sv
tb/tb_channel_slice_allocator.sv
